// File: hdl/two_wheel_speed_balancer_defines.svh
// ----------------------------------------------------------------------------
// two_wheel_speed_balancer_defines
// Assertion macros used by the speed balancer RTL.
// ----------------------------------------------------------------------------
`ifndef TWO_WHEEL_SPEED_BALANCER_DEFINES_SVH
`define TWO_WHEEL_SPEED_BALANCER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TWS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define TWS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/tws_pkg.sv
// ----------------------------------------------------------------------------
// tws_pkg
// Types, constants and reciprocal factors for the two-wheel speed balancer.
// ----------------------------------------------------------------------------
package tws_pkg;

   localparam int COUNTER_BITS = 16;
   localparam int REG_W        = 16;
   localparam int PCT_W        = 8;
   localparam int PCT_MAX      = 100;
   localparam int PCT_CLAMP_W  = 7;
   localparam int SPEED_PROD_W = REG_W + PCT_CLAMP_W;

   localparam logic [REG_W-1:0] FULL_SCALE_RESET = 16'd1000;
   localparam logic [REG_W-1:0] RATIO_RESET      = 16'd4096;

   // floor(x / 100) = (x * DIV100_MAGIC) >> DIV100_SHIFT for x < 2^23
   localparam int DIV100_SHIFT   = 30;
   localparam int DIV100_MAGIC_W = 24;
   localparam logic [DIV100_MAGIC_W-1:0] DIV100_MAGIC =
      DIV100_MAGIC_W'(((64'd1 << DIV100_SHIFT) + 64'd99) / 64'd100);

   // floor(x / 10) for x < 2^(COUNTER_BITS+1)
   localparam int DIV10_SHIFT   = COUNTER_BITS + 5;
   localparam int DIV10_MAGIC_W = COUNTER_BITS + 2;
   localparam logic [DIV10_MAGIC_W-1:0] DIV10_MAGIC =
      DIV10_MAGIC_W'(((64'd1 << DIV10_SHIFT) + 64'd9) / 64'd10);

   localparam int BOOST_STEP   = 3;
   localparam int EDGE_MIN     = 8;
   localparam int DROP_OFFSET  = 16;
   localparam int CORR_GAIN    = 5;
   localparam int Q_FRAC       = 12;
   localparam int CORR_MAX     = 32767;
   localparam int CORR_MIN     = -32768;

   typedef enum logic [1:0] {
      OP_LEFT_EDGE  = 2'd0,
      OP_RIGHT_EDGE = 2'd1,
      OP_SAMPLE     = 2'd2,
      OP_SET_SPEED  = 2'd3
   } op_type;

   typedef enum logic [0:0] {
      CSR_FULL_SCALE = 1'b0,
      CSR_RATIO      = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [COUNTER_BITS-1:0] left;
      logic [COUNTER_BITS-1:0] right;
      logic [REG_W-1:0]        base;
      logic [REG_W-1:0]        boost;
      logic signed [REG_W-1:0] corr;
      logic [REG_W-1:0]        ratio;
   } sample_in_type;

   typedef struct packed {
      logic [REG_W-1:0]        boost;
      logic signed [REG_W-1:0] corr;
      logic [REG_W-1:0]        motor0;
      logic [REG_W-1:0]        motor1;
   } sample_out_type;

endpackage

// File: hdl/tws_req_if.sv
// ----------------------------------------------------------------------------
// tws_req_if
// Request channel: encoder edges, sample ticks and set-speed commands.
// ----------------------------------------------------------------------------
interface tws_req_if;
   import tws_pkg::*;

   logic             valid;
   logic             ready;
   op_type           op;
   logic [PCT_W-1:0] speed_percent;

   modport source (output valid, op, speed_percent, input ready);
   modport sink (input valid, op, speed_percent, output ready);
endinterface

// File: hdl/tws_rsp_if.sv
// ----------------------------------------------------------------------------
// tws_rsp_if
// Response channel: the two motor compare values.
// ----------------------------------------------------------------------------
interface tws_rsp_if;
   import tws_pkg::*;

   logic             valid;
   logic             ready;
   logic [REG_W-1:0] motor0_compare;
   logic [REG_W-1:0] motor1_compare;

   modport source (output valid, motor0_compare, motor1_compare, input ready);
   modport sink (input valid, motor0_compare, motor1_compare, output ready);
endinterface

// File: hdl/two_wheel_speed_balancer.sv
// ----------------------------------------------------------------------------
// two_wheel_speed_balancer
// Balances two wheel motors from encoder edge counts.
// Usage: send items on req_bus (op: left edge, right edge, sample tick, set
// speed with speed_percent). Edges bump wrapping counters; set speed loads
// the base compare as full_scale * min(percent,100) / 100. A sample tick
// reads and clears both counts and, while the base is nonzero, updates the
// stall boost and balance correction and returns one beat on rsp_bus with
// the two motor compares. Other items return nothing.
// A sample tick is registered in the input stage, executes from there,
// and its result beat is registered in the output register.
// Throughput: one item per cycle unless stalled; execute does all work in
// one pass, the widest path being the right-count times ratio multiplier.
// Stall: a held result beat keeps the next sample tick with a live base
// waiting in the execute stage, and that tick holds off the input; items
// ahead of it keep flowing, and a new beat loads in the cycle the old one
// is taken.
// Reset: synchronous; clears counts, base, boost, correction and restores
// the full-scale period to 1000, ratio = 1.0 (Q4.12). Write csr_* only
// while idle.
// ----------------------------------------------------------------------------
`include "two_wheel_speed_balancer_defines.svh"

module two_wheel_speed_balancer (
   input  logic                   clock,
   input  logic                   reset,
   tws_req_if.sink                req_bus,
   tws_rsp_if.source              rsp_bus,
   input  logic                   csr_we,
   input  tws_pkg::csr_index_type csr_index,
   input  logic [tws_pkg::REG_W-1:0] csr_wdata
);
   import tws_pkg::*;

   localparam int BPROD_W = SPEED_PROD_W + DIV100_MAGIC_W;

   // configuration
   logic [REG_W-1:0] full_scale_ff, full_scale_in;
   logic [REG_W-1:0] ratio_ff, ratio_in;

   // input stage
   logic                    stg_valid_ff, stg_valid_in;
   op_type                  stg_op_ff;
   logic [SPEED_PROD_W-1:0] stg_prod_ff;
   logic [PCT_CLAMP_W-1:0]  pct_clamped;
   logic [SPEED_PROD_W-1:0] speed_prod;
   logic                    req_take;

   // block state
   logic [COUNTER_BITS-1:0] left_ff, left_in;
   logic [COUNTER_BITS-1:0] right_ff, right_in;
   logic [REG_W-1:0]        base_compare_ff, base_compare_in;
   logic [REG_W-1:0]        stall_boost_ff, stall_boost_in;
   logic signed [REG_W-1:0] correction_ff, correction_in;

   // execute
   logic [BPROD_W-1:0] base_prod;
   logic [REG_W-1:0]   new_base;
   logic               produces_result;
   logic               exec_fire;
   sample_in_type      smp_in;
   sample_out_type     smp_out;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [REG_W-1:0] motor0_ff;
   logic [REG_W-1:0] motor1_ff;
   logic             rsp_load;

   // Config writes are to land only while idle (the block does not enforce
   // this), so the period is safe to fold into the speed product at the input.
   always_comb begin
      full_scale_in = full_scale_ff;
      ratio_in      = ratio_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FULL_SCALE: full_scale_in = csr_wdata;
            CSR_RATIO:      ratio_in      = csr_wdata;
            default:        full_scale_in = full_scale_ff;
         endcase
      end
   end

   // Clamp the percent and form period * percent ahead of the divide.
   always_comb begin
      pct_clamped = (req_bus.speed_percent > PCT_W'(PCT_MAX)) ?
                    PCT_CLAMP_W'(PCT_MAX) : req_bus.speed_percent[PCT_CLAMP_W-1:0];
      speed_prod  = SPEED_PROD_W'(full_scale_ff) * SPEED_PROD_W'(pct_clamped);
   end

   // Hold the staged item until it can execute. Only a sample tick that
   // yields a result can wait, and only on a full, unread output register.
   always_comb begin
      produces_result = (stg_op_ff == OP_SAMPLE) && (base_compare_ff != '0);
      exec_fire       = stg_valid_ff &&
                        (!produces_result || !rsp_valid_ff || rsp_bus.ready);
      req_take        = req_bus.valid && req_bus.ready;
      stg_valid_in    = req_take || (stg_valid_ff && !exec_fire);
      req_bus.ready   = !stg_valid_ff || exec_fire;
   end

   // divide by 100 through a reciprocal multiply
   always_comb begin
      base_prod = BPROD_W'(stg_prod_ff) * BPROD_W'(DIV100_MAGIC);
      new_base  = base_prod[DIV100_SHIFT +: REG_W];
   end

   always_comb begin
      smp_in.left  = left_ff;
      smp_in.right = right_ff;
      smp_in.base  = base_compare_ff;
      smp_in.boost = stall_boost_ff;
      smp_in.corr  = correction_ff;
      smp_in.ratio = ratio_ff;
   end

   tws_sample_unit u_sample (
      .smp_in  (smp_in),
      .smp_out (smp_out)
   );

   // Advance the block state for the executing item.
   always_comb begin
      left_in         = left_ff;
      right_in        = right_ff;
      base_compare_in = base_compare_ff;
      stall_boost_in  = stall_boost_ff;
      correction_in   = correction_ff;
      if (exec_fire) begin
         unique case (stg_op_ff)
            OP_LEFT_EDGE: begin
               left_in = left_ff + COUNTER_BITS'(1);
            end
            OP_RIGHT_EDGE: begin
               right_in = right_ff + COUNTER_BITS'(1);
            end
            OP_SET_SPEED: begin
               // a new base drops any stall boost; the correction stays
               if (new_base != base_compare_ff) begin
                  base_compare_in = new_base;
                  stall_boost_in  = '0;
               end
            end
            OP_SAMPLE: begin
               left_in  = '0;
               right_in = '0;
               if (produces_result) begin
                  stall_boost_in = smp_out.boost;
                  correction_in  = smp_out.corr;
               end
            end
            default: begin
               left_in = left_ff;
            end
         endcase
      end
   end

   // Load the output register on a result; drop valid once the beat is taken.
   always_comb begin
      rsp_load     = exec_fire && produces_result;
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_scale_ff   <= FULL_SCALE_RESET;
         ratio_ff        <= RATIO_RESET;
         stg_valid_ff    <= 1'b0;
         left_ff         <= '0;
         right_ff        <= '0;
         base_compare_ff <= '0;
         stall_boost_ff  <= '0;
         correction_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         full_scale_ff   <= full_scale_in;
         ratio_ff        <= ratio_in;
         stg_valid_ff    <= stg_valid_in;
         left_ff         <= left_in;
         right_ff        <= right_in;
         base_compare_ff <= base_compare_in;
         stall_boost_ff  <= stall_boost_in;
         correction_ff   <= correction_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         stg_op_ff   <= req_bus.op;
         stg_prod_ff <= speed_prod;
      end
      if (rsp_load) begin
         motor0_ff <= smp_out.motor0;
         motor1_ff <= smp_out.motor1;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.motor0_compare = motor0_ff;
   assign rsp_bus.motor1_compare = motor1_ff;

   // A sample tick always leaves both counters cleared.
   `TWS_ASSERT_NEXT(a_sample_clears_counts, clock, reset, exec_fire && stg_op_ff == OP_SAMPLE, left_ff == '0 && right_ff == '0, "sample tick did not clear edge counts")
   // A changed base takes effect and clears the stall boost.
   `TWS_ASSERT_NEXT(a_new_base_clears_boost, clock, reset, exec_fire && stg_op_ff == OP_SET_SPEED && new_base != base_compare_ff, stall_boost_ff == '0 && base_compare_ff == $past(new_base), "new base did not clear boost")
   // A result beat only starts from an executed sample tick with a live base.
   `TWS_ASSERT_SAME(a_rsp_from_sample, clock, reset, $rose(rsp_valid_ff), $past(exec_fire && produces_result), "result beat without a sample tick")

endmodule

// File: hdl/tws_sample_unit.sv
// ----------------------------------------------------------------------------
// tws_sample_unit
// Sample-tick math: stall boost, balance correction and motor compares.
// ----------------------------------------------------------------------------
module tws_sample_unit (
   input  tws_pkg::sample_in_type  smp_in,
   output tws_pkg::sample_out_type smp_out
);
   import tws_pkg::*;

   localparam int CB        = COUNTER_BITS;
   localparam int DROP_W    = CB - 2;
   localparam int DPROD_W   = 2 * CB + 3;
   localparam int CMP_W     = (DROP_W > REG_W) ? DROP_W : REG_W;
   localparam int RPROD_W   = CB + REG_W;
   localparam int ACC_W     = CB + 21;
   localparam int MOT_W     = REG_W + 3;

   logic                    any_zero;
   logic                    both_busy;
   logic [REG_W:0]          boost_inc;
   logic [CB:0]             sum_m16;
   logic [DPROD_W-1:0]      drop_prod;
   logic [DROP_W-1:0]       drop;
   logic [CMP_W-1:0]        drop_ext;
   logic [CMP_W-1:0]        boost_ext;
   logic [REG_W-1:0]        boost_new;

   logic [RPROD_W-1:0]      r_prod;
   logic signed [ACC_W-1:0] l_scaled;
   logic signed [ACC_W-1:0] r_scaled;
   logic signed [ACC_W-1:0] diff;
   logic signed [ACC_W-1:0] gained;
   logic signed [ACC_W-1:0] corr_scaled;
   logic signed [ACC_W-1:0] acc;
   logic signed [ACC_W-1:0] acc_adj;
   logic signed [ACC_W-1:0] quot;
   logic signed [REG_W-1:0] corr_new;

   logic signed [REG_W:0]   corr_w;
   logic signed [REG_W:0]   half;
   logic [REG_W:0]          base_sum;
   logic signed [MOT_W-1:0] m0;
   logic signed [MOT_W-1:0] m1;

   function automatic logic [REG_W-1:0] clamp_u16(input logic signed [MOT_W-1:0] v);
      logic [REG_W-1:0] res;
      if (v < 0) begin
         res = '0;
      end else if (v > MOT_W'(signed'(65535))) begin
         res = '1;
      end else begin
         res = v[REG_W-1:0];
      end
      return res;
   endfunction

   // stall boost
   always_comb begin
      any_zero  = (smp_in.left == '0) || (smp_in.right == '0);
      both_busy = (smp_in.left > CB'(EDGE_MIN)) && (smp_in.right > CB'(EDGE_MIN));
      boost_inc = {1'b0, smp_in.boost} + (REG_W+1)'(BOOST_STEP);
      sum_m16   = {1'b0, smp_in.left} + {1'b0, smp_in.right} - (CB+1)'(DROP_OFFSET);
      drop_prod = DPROD_W'(sum_m16) * DPROD_W'(DIV10_MAGIC);
      drop      = drop_prod[DIV10_SHIFT +: DROP_W];
      drop_ext  = CMP_W'(drop);
      boost_ext = CMP_W'(smp_in.boost);

      priority if (any_zero) begin
         boost_new = boost_inc[REG_W] ? '1 : boost_inc[REG_W-1:0];
      end else if ((smp_in.boost != '0) && both_busy) begin
         boost_new = (drop_ext >= boost_ext) ? '0 : REG_W'(boost_ext - drop_ext);
      end else begin
         boost_new = smp_in.boost;
      end
   end

   // balance correction, Q4.12 accumulate then truncate toward zero
   always_comb begin
      r_prod      = RPROD_W'(smp_in.right) * RPROD_W'(smp_in.ratio);
      l_scaled    = signed'(ACC_W'({smp_in.left, {Q_FRAC{1'b0}}}));
      r_scaled    = signed'(ACC_W'(r_prod));
      diff        = l_scaled - r_scaled;
      gained      = diff * ACC_W'(signed'(CORR_GAIN));
      corr_scaled = ACC_W'(signed'(smp_in.corr)) <<< Q_FRAC;
      acc         = corr_scaled + gained;
      acc_adj     = acc + ((acc < 0) ? ACC_W'(signed'((1 << Q_FRAC) - 1)) : '0);
      quot        = acc_adj >>> Q_FRAC;

      priority if (quot > ACC_W'(CORR_MAX)) begin
         corr_new = REG_W'(CORR_MAX);
      end else if (quot < ACC_W'(CORR_MIN)) begin
         corr_new = REG_W'(CORR_MIN);
      end else begin
         corr_new = quot[REG_W-1:0];
      end
   end

   // motor compares
   always_comb begin
      corr_w   = (REG_W+1)'(corr_new);
      half     = (corr_w + signed'({{REG_W{1'b0}}, corr_w[REG_W]})) >>> 1;
      base_sum = {1'b0, smp_in.base} + {1'b0, boost_new};
      m0       = signed'(MOT_W'(base_sum)) - MOT_W'(half);
      m1       = signed'(MOT_W'(base_sum)) + MOT_W'(half);

      smp_out.boost  = boost_new;
      smp_out.corr   = corr_new;
      smp_out.motor0 = clamp_u16(m0);
      smp_out.motor1 = clamp_u16(m1);
   end

endmodule
